// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the sorted insert deque.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SID_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/sid_pkg.sv -----
// ----------------------------------------------------------------------------
// sid_pkg
// Types and constants shared by the sorted insert deque cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sid_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [2:0] {
      OP_PUSH_HEAD = 3'd0,
      OP_PUSH_TAIL = 3'd1,
      OP_INSERT    = 3'd2,
      OP_POP_HEAD  = 3'd3,
      OP_POP_TAIL  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // What every cell does this cycle.
   typedef enum logic [2:0] {
      MODE_HOLD      = 3'd0,
      MODE_PUSH_HEAD = 3'd1,
      MODE_PUSH_TAIL = 3'd2,
      MODE_INSERT    = 3'd3,
      MODE_POP_HEAD  = 3'd4
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  key;
      logic [7:0]  tag;
      cnt_type     count;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- src/sid_cell.sv -----
// ----------------------------------------------------------------------------
// sid_cell
// One list slot: holds a (key, tag) entry, compares against the new key and
// moves data to or from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_cell
   import sid_pkg::*;
(
   input  wire          clock,
   input  idx_type      idx,
   input  cell_ctl_type ctl,
   input  wire  [7:0]   left_key,
   input  wire  [7:0]   left_tag,
   input  wire  [7:0]   right_key,
   input  wire  [7:0]   right_tag,
   input  wire          hit_in,
   input  wire  [7:0]   tail_key_in,
   input  wire  [7:0]   tail_tag_in,
   output logic [7:0]   key,
   output logic [7:0]   tag,
   output logic         hit_out,
   output logic [7:0]   tail_key_out,
   output logic [7:0]   tail_tag_out
);

   logic [7:0] key_ff, key_in;
   logic [7:0] tag_ff, tag_in;
   cnt_type    pos;
   logic       occupied;
   logic       first_free;
   logic       is_last;
   logic       gte;

   always_comb begin
      pos        = CNT_W'(idx);
      occupied   = pos < ctl.count;
      first_free = pos == ctl.count;
      is_last    = (pos + CNT_W'(1)) == ctl.count;
      gte        = occupied && (key_ff >= ctl.key);
      hit_out    = hit_in | gte;
      // tail entry travels toward the head
      tail_key_out = is_last ? key_ff : tail_key_in;
      tail_tag_out = is_last ? tag_ff : tail_tag_in;
   end

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      case (ctl.mode)
         MODE_PUSH_HEAD: begin
            key_in = left_key;
            tag_in = left_tag;
         end
         MODE_PUSH_TAIL: begin
            if (first_free) begin
               key_in = ctl.key;
               tag_in = ctl.tag;
            end
         end
         MODE_INSERT: begin
            if (hit_in) begin
               key_in = left_key;
               tag_in = left_tag;
            end else if (gte || first_free) begin
               key_in = ctl.key;
               tag_in = ctl.tag;
            end
         end
         MODE_POP_HEAD: begin
            key_in = right_key;
            tag_in = right_tag;
         end
         default: begin
            key_in = key_ff;
            tag_in = tag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign key = key_ff;
   assign tag = tag_ff;

endmodule

`default_nettype wire

// ----- src/sorted_insert_deque_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_deque_unit
// Bounded (key, tag) list with head/tail push, ordered insert and head/tail
// pop, built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The unit holds up to DEPTH entries, head at cell 0. Every request
// transaction returns exactly one response transaction carrying a status, the
// popped entry (zero when nothing is popped) and the entry count after the
// operation. Throughput is one transaction per clock: all cells compare their
// key against the new key and shift in the same cycle the request is taken,
// and the response sits in a single output register, so a request is taken
// whenever that register is empty or being drained. The response is registered
// and shows in the cycle after the request is taken. A push on a full list
// answers FULL and leaves the list alone; a pop on an empty list answers
// EMPTY. An ordered insert lands ahead of the first entry whose key is
// greater than or equal to the new key, or at the tail if there is none.
// Stored entries have no reset; only the count and response valid are cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_insert_deque_unit
   import sid_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_op,
   input  wire  [7:0]  req_key,
   input  wire  [7:0]  req_tag,
   // response channel
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_out_key,
   output logic [7:0]  rsp_out_tag,
   output logic [4:0]  rsp_count
);

   // cell row wiring, each element tied to one cell
   logic [7:0]   cell_key  [DEPTH];
   logic [7:0]   cell_tag  [DEPTH];
   logic         cell_hit  [DEPTH];
   logic [7:0]   cell_tkey [DEPTH];
   logic [7:0]   cell_ttag [DEPTH];

   cnt_type      count_ff, count_in;
   logic         rsp_valid_ff, rsp_valid_in;
   status_type   status_ff, status_in;
   logic [7:0]   okey_ff, okey_in;
   logic [7:0]   otag_ff, otag_in;
   logic [4:0]   ocnt_ff;

   logic         req_accept;
   logic         list_full;
   logic         list_empty;
   cell_ctl_type ctl;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign list_full  = count_ff == CNT_W'(DEPTH);
   assign list_empty = count_ff == '0;

   // Decode the transaction into a row command plus response fields.
   always_comb begin
      ctl.mode  = MODE_HOLD;
      ctl.key   = req_key;
      ctl.tag   = req_tag;
      ctl.count = count_ff;
      status_in = ST_DONE;
      okey_in   = '0;
      otag_in   = '0;
      count_in  = count_ff;
      case (req_op)
         OP_PUSH_HEAD, OP_PUSH_TAIL, OP_INSERT: begin
            if (list_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
               case (req_op)
                  OP_PUSH_HEAD: ctl.mode = MODE_PUSH_HEAD;
                  OP_PUSH_TAIL: ctl.mode = MODE_PUSH_TAIL;
                  default:      ctl.mode = MODE_INSERT;
               endcase
            end
         end
         OP_POP_HEAD, OP_POP_TAIL: begin
            if (list_empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
               if (req_op == OP_POP_HEAD) begin
                  ctl.mode = MODE_POP_HEAD;
                  okey_in  = cell_key[0];
                  otag_in  = cell_tag[0];
               end else begin
                  // tail pop only shortens the list; entry comes up the chain
                  okey_in  = cell_tkey[0];
                  otag_in  = cell_ttag[0];
               end
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
      if (!req_accept) begin
         ctl.mode = MODE_HOLD;
         count_in = count_ff;
      end
   end

   // Cell row: left neighbor feeds shifts toward the tail, right neighbor
   // feeds head pops, hit ripples toward the tail, tail entry toward head.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      sid_cell u_cell (
         .clock        (clock),
         .idx          (idx_type'(i)),
         .ctl          (ctl),
         .left_key     ((i == 0) ? req_key : cell_key[(i == 0) ? 0 : i-1]),
         .left_tag     ((i == 0) ? req_tag : cell_tag[(i == 0) ? 0 : i-1]),
         .right_key    (cell_key[(i == DEPTH-1) ? i : i+1]),
         .right_tag    (cell_tag[(i == DEPTH-1) ? i : i+1]),
         .hit_in       ((i == 0) ? 1'b0 : cell_hit[(i == 0) ? 0 : i-1]),
         .tail_key_in  ((i == DEPTH-1) ? 8'd0 : cell_tkey[(i == DEPTH-1) ? i : i+1]),
         .tail_tag_in  ((i == DEPTH-1) ? 8'd0 : cell_ttag[(i == DEPTH-1) ? i : i+1]),
         .key          (cell_key[i]),
         .tag          (cell_tag[i]),
         .hit_out      (cell_hit[i]),
         .tail_key_out (cell_tkey[i]),
         .tail_tag_out (cell_ttag[i])
      );
   end

   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded only when a transaction is taken
   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff <= status_in;
         okey_ff   <= okey_in;
         otag_ff   <= otag_in;
         ocnt_ff   <= 5'(count_in);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_out_key = okey_ff;
   assign rsp_out_tag = otag_ff;
   assign rsp_count   = ocnt_ff;

   // count never passes capacity
   `SID_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   // count moves only on a taken transaction
   `SID_ASSERT_NEXT(a_count_hold, clock, reset, !req_accept, count_ff == $past(count_ff))
   // a FULL answer means the list really was full
   `SID_ASSERT_NEXT(a_full_status, clock, reset, req_accept && status_in == ST_FULL,
      count_ff == CNT_W'(DEPTH) && rsp_status == ST_FULL)

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_insert_deque_unit. A queue-based model
// predicts one response per accepted request. A monitor checks every response
// against the oldest prediction, field by field. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_top;
   import sid_pkg::*;

   // One held list entry, and one predicted response transaction.
   typedef struct packed {
      logic [7:0] key;
      logic [7:0] tag;
   } entry_type;

   typedef struct packed {
      status_type status;
      logic [7:0] key;
      logic [7:0] tag;
      logic [4:0] count;
   } rsp_type;

   // Highest value of the 3-bit op field; codes above OP_POP_TAIL are unused.
   localparam logic [2:0] OP_FIELD_MAX = '1;
   // Slowest legal run is roughly 1700 items with long idles; keep a wide margin.
   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_op;
   logic [7:0]  req_key;
   logic [7:0]  req_tag;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_out_key;
   logic [7:0]  rsp_out_tag;
   logic [4:0]  rsp_count;

   // Model contents (head at index 0) and responses still owed by the DUT.
   entry_type held_q[$];
   rsp_type   owed_rsp_q[$];

   // When set, neither side inserts idle cycles.
   bit steady;

   int errors;
   int cycles;
   int rsp_checked;
   int full_hits;
   int empty_hits;
   int op_seen [8];

   sorted_insert_deque_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_key     (req_key),
      .req_tag     (req_tag),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_out_key (rsp_out_key),
      .rsp_out_tag (rsp_out_tag),
      .rsp_count   (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model of the list: apply one request, return the response it causes.
   // ------------------------------------------------------------------------
   function automatic rsp_type deque_apply(logic [2:0] op, logic [7:0] key,
                                           logic [7:0] tag);
      rsp_type   r;
      entry_type e;
      int        pos;
      r.status = ST_DONE;
      r.key    = '0;
      r.tag    = '0;
      e.key    = key;
      e.tag    = tag;
      case (op)
         OP_PUSH_HEAD, OP_PUSH_TAIL, OP_INSERT: begin
            if (held_q.size() >= DEPTH) begin
               r.status = ST_FULL;
            end else if (op == OP_PUSH_HEAD) begin
               held_q.push_front(e);
            end else if (op == OP_PUSH_TAIL) begin
               held_q.push_back(e);
            end else begin
               // land ahead of the first key >= new key, ties included
               pos = 0;
               while (pos < held_q.size() && held_q[pos].key < key) pos++;
               if (pos == held_q.size()) held_q.push_back(e);
               else held_q.insert(pos, e);
            end
         end
         OP_POP_HEAD, OP_POP_TAIL: begin
            if (held_q.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (op == OP_POP_HEAD) e = held_q.pop_front();
               else e = held_q.pop_back();
               r.key = e.key;
               r.tag = e.tag;
            end
         end
         default: ; // unused codes leave the list alone
      endcase
      r.count = 5'(held_q.size());
      return r;
   endfunction

   // Idle length: mostly none, some short, a few long.
   function automatic int idle_len();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic check_field(string what, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         errors++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor. Responses are checked before the request of the same edge is
   // predicted; a response can never belong to a request taken that edge.
   // All signals are read as they stood before the edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsp_q.size() == 0) begin
               $display("%0t: response transaction with nothing expected", $time);
               errors++;
            end else begin
               want = owed_rsp_q.pop_front();
               check_field("status", int'(want.status), int'(rsp_status));
               check_field("out_key", int'(want.key), int'(rsp_out_key));
               check_field("out_tag", int'(want.tag), int'(rsp_out_tag));
               check_field("count", int'(want.count), int'(rsp_count));
               rsp_checked++;
               if (want.status == ST_FULL) full_hits++;
               if (want.status == ST_EMPTY) empty_hits++;
            end
         end
         if (req_valid && !req_stall) begin
            owed_rsp_q.push_back(deque_apply(req_op, req_key, req_tag));
            op_seen[req_op]++;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d responses outstanding",
                  $time, owed_rsp_q.size());
         $display("[sorted_insert_deque_unit] ERROR");
         $finish;
      end
   end

   // Response side back-pressure: random stalls, with clear runs between.
   initial begin
      int n;
      @(posedge clock);
      forever begin
         n = idle_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Request side. Called at a clock edge; returns at the edge the
   // transaction was taken, or later after an idle gap.
   // ------------------------------------------------------------------------
   task automatic send_item(logic [2:0] op, logic [7:0] key, logic [7:0] tag);
      int gap;
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      req_tag   <= tag;
      do @(posedge clock); while (req_stall);
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off new requests until every owed response is back.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_rsp_q.size() != 0);
   endtask

   function automatic logic [7:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return 8'($urandom_range(0, 255));
      if (r < 8) return 8'($urandom_range(0, 7));    // narrow: lots of ties
      if (r == 8) return 8'h00;
      return 8'hFF;
   endfunction

   // push_pct steers the fill level; a few percent are unused codes.
   function automatic logic [2:0] pick_op(int push_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 3'($urandom_range(OP_POP_TAIL + 1, OP_FIELD_MAX));
      if ($urandom_range(0, 99) < push_pct) begin
         r = $urandom_range(0, 3);
         if (r == 0) return OP_PUSH_HEAD;
         if (r == 1) return OP_PUSH_TAIL;
         return OP_INSERT;
      end
      if ($urandom_range(0, 1) == 0) return OP_POP_HEAD;
      return OP_POP_TAIL;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Empty pops, single-entry pops, ties, key/tag extremes, unused codes.
   task automatic test_edge_cases();
      int code;
      send_item(OP_POP_HEAD, 8'hA5, 8'h5A);
      send_item(OP_POP_TAIL, 8'hFF, 8'hFF);
      send_item(OP_PUSH_HEAD, 8'h00, 8'h00);
      send_item(OP_POP_TAIL, 8'h00, 8'h00);
      send_item(OP_PUSH_TAIL, 8'hFF, 8'hFF);
      send_item(OP_POP_HEAD, 8'h00, 8'h00);
      send_item(OP_INSERT, 8'h80, 8'h01);      // into empty list
      send_item(OP_INSERT, 8'h80, 8'h02);      // tie: lands ahead
      send_item(OP_INSERT, 8'h80, 8'h03);
      send_item(OP_INSERT, 8'h00, 8'h04);      // new head
      send_item(OP_INSERT, 8'hFF, 8'h05);      // new tail
      send_item(OP_INSERT, 8'h7F, 8'h06);
      send_item(OP_PUSH_HEAD, 8'h80, 8'h07);   // breaks the order on purpose
      send_item(OP_PUSH_TAIL, 8'h00, 8'h08);
      send_item(OP_INSERT, 8'h40, 8'h09);      // insert into unsorted list
      for (code = OP_POP_TAIL + 1; code <= OP_FIELD_MAX; code++)
         send_item(3'(code), 8'hFF, 8'hFF);
      while (held_q.size() > 0 || owed_rsp_q.size() > 0) begin
         // alternate ends until empty; model size may lag by in-flight pops
         send_item(OP_POP_HEAD, 8'h00, 8'h00);
         send_item(OP_POP_TAIL, 8'h00, 8'h00);
         pause_until_drained();
      end
      send_item(OP_POP_TAIL, 8'h00, 8'h00);
      pause_until_drained();
   endtask

   // Fill to DEPTH, hit every push kind on a full list, then empty it.
   task automatic test_full_list();
      repeat (DEPTH) send_item(OP_INSERT, pick_key(), 8'($urandom_range(0, 255)));
      send_item(OP_PUSH_HEAD, 8'h11, 8'h22);
      send_item(OP_PUSH_TAIL, 8'h33, 8'h44);
      send_item(OP_INSERT, 8'h55, 8'h66);
      send_item(OP_POP_TAIL, 8'h00, 8'h00);
      send_item(OP_PUSH_HEAD, 8'hEE, 8'hDD);   // full again
      send_item(OP_INSERT, 8'h00, 8'hFF);
      repeat (DEPTH) send_item(OP_POP_HEAD, 8'h00, 8'h00);
      send_item(OP_POP_HEAD, 8'h00, 8'h00);
      pause_until_drained();
   endtask

   // Rounds with different push bias so the list sweeps empty to full.
   task automatic test_random_traffic();
      int push_bias [8] = '{75, 25, 50, 85, 15, 50, 65, 35};
      foreach (push_bias[r]) begin
         steady = (r == 3);                    // one round with no idling
         repeat (200)
            send_item(pick_op(push_bias[r]), pick_key(), 8'($urandom_range(0, 255)));
         steady = 1'b0;
         if (r == 1 || r == 5) pause_until_drained();
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_op    <= OP_PUSH_HEAD;
      req_key   <= '0;
      req_tag   <= '0;
      rsp_stall <= 1'b0;
      steady     = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_cases();
      test_full_list();
      test_random_traffic();

      req_valid <= 1'b0;
      do @(posedge clock); while (owed_rsp_q.size() != 0);
      repeat (4) @(posedge clock);

      $display("Checked %0d responses: %0d head pushes, %0d tail pushes, %0d inserts,",
               rsp_checked, op_seen[OP_PUSH_HEAD], op_seen[OP_PUSH_TAIL],
               op_seen[OP_INSERT]);
      $display("%0d head pops, %0d tail pops, %0d full pushes, %0d empty pops, %0d errors",
               op_seen[OP_POP_HEAD], op_seen[OP_POP_TAIL], full_hits, empty_hits, errors);
      if (errors == 0) begin
         $display("[sorted_insert_deque_unit] OK");
      end else begin
         $display("[sorted_insert_deque_unit] ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/sid_pkg.sv
src/sid_cell.sv
src/sorted_insert_deque_unit.sv
bench/tb_top.sv
